/* src/ahc_pkg.sv */
package ahc_pkg;

   // Fixed field widths of the item formats.
   localparam int SYM_W      = 9;
   localparam int WEIGHT_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 1'b1;

   // Mode codes.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [WEIGHT_W-1:0] LIMIT_RESET = 16'd2000;

   typedef struct packed {
      logic [SYM_W-1:0] symbol_in;
      logic             code_bit_in;
   } req_type;

   typedef struct packed {
      logic             code_bit_out;
      logic [SYM_W-1:0] symbol_out;
      logic             symbol_valid;
      logic             last;
   } rsp_type;

   // Configuration seen by the engine.
   typedef struct packed {
      logic                mode;
      logic [WEIGHT_W-1:0] rescale_limit;
      logic                cursor_home;
   } cfg_type;

   // Engine status towards the top level.
   typedef struct packed {
      logic clearing;
      logic halving;
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DEC_RD,
      ST_DEC_SEL,
      ST_DEC_EMIT,
      ST_ENC_RD_PAR,
      ST_ENC_RD_CHILD,
      ST_ENC_PUSH,
      ST_ENC_EMIT,
      ST_UPD_RD_LEAF,
      ST_UPD_INC,
      ST_UPD_SIB,
      ST_RAISE_RD_SIB,
      ST_RAISE_RD_PAR,
      ST_RAISE_WR,
      ST_RAISE_NEXT,
      ST_HALVE_RD,
      ST_HALVE_WR,
      ST_UPD_RESUME,
      ST_SWAP_RD_UP,
      ST_SWAP_RD_UNCLE,
      ST_SWAP_RD_W,
      ST_SWAP_CMP,
      ST_SWAP_FIX
   } state_type;

endpackage

/* src/ahc_ram.sv */
module ahc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* src/ahc_engine.sv */
module ahc_engine import ahc_pkg::*; #(
   parameter int LEAF_COUNT = 512,
   parameter int MAX_DEPTH  = 64,
   localparam int NW  = $clog2(2 * LEAF_COUNT),
   localparam int CW  = NW - 1,
   localparam int NMW = NW + WEIGHT_W,
   localparam int CMW = 2 * NW
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   output status_type     status,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_payload,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_payload,
   output logic           nm_we,
   output logic [NW-1:0]  nm_waddr,
   output logic [NMW-1:0] nm_wdata,
   output logic [NW-1:0]  nm_raddr,
   input  logic [NMW-1:0] nm_rdata,
   output logic           cm_we,
   output logic [CW-1:0]  cm_waddr,
   output logic [CMW-1:0] cm_wdata,
   output logic [CW-1:0]  cm_raddr,
   input  logic [CMW-1:0] cm_rdata
);

   localparam int NODE_COUNT = 2 * LEAF_COUNT;
   localparam int DPW        = $clog2(MAX_DEPTH + 1);
   localparam logic [NW-1:0]  ROOT       = NW'(1);
   localparam logic [NW-1:0]  LAST_NODE  = NW'(NODE_COUNT - 1);
   localparam logic [NW-1:0]  FIRST_LEAF = NW'(LEAF_COUNT);
   localparam logic [DPW-1:0] DEPTH_MAX  = DPW'(MAX_DEPTH);

   state_type st_ff, st_in;

   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] leaf_ff, leaf_in;
   logic [NW-1:0] child_ff, child_in;
   logic [NW-1:0] enc_node_ff, enc_node_in;
   logic [NW-1:0] enc_par_ff, enc_par_in;
   logic [NW-1:0] ra_ff, ra_in;
   logic [NW-1:0] rpa_ff, rpa_in;
   logic [NW-1:0] rb_ff, rb_in;
   logic [NW-1:0] leafpa_ff, leafpa_in;
   logic [NW-1:0] au_ff, au_in;
   logic [NW-1:0] ua_ff, ua_in;
   logic [NW-1:0] uua_ff, uua_in;
   logic [NW-1:0] bu_ff, bu_in;
   logic [NW-1:0] ul_ff, ul_in;
   logic [NW-1:0] ur_ff, ur_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [WEIGHT_W-1:0] rwa_ff, rwa_in;
   logic [WEIGHT_W-1:0] wau_ff, wau_in;
   logic cbit_ff, cbit_in;
   logic ret_swap_ff, ret_swap_in;
   logic [MAX_DEPTH-1:0] sr_ff, sr_in;
   logic [DPW-1:0] depth_ff, depth_in;
   logic [DPW-1:0] emit_ff, emit_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Read data fields and derived conditions.
   logic [NW-1:0]       nm_par;
   logic [WEIGHT_W-1:0] nm_w;
   logic [NW-1:0]       cm_l, cm_r;
   logic                req_take, slot_free, sym_ok;
   logic [NW-1:0]       req_leaf, child_sel, uncle, raise_sib;
   logic                child_leaf, emit_last, ua_left, swap_do;
   logic [DPW-1:0]      depth_inc;
   logic                out_load;
   rsp_type             out_data;

   assign nm_par = nm_rdata[NMW-1:WEIGHT_W];
   assign nm_w   = nm_rdata[WEIGHT_W-1:0];
   assign cm_l   = cm_rdata[CMW-1:NW];
   assign cm_r   = cm_rdata[NW-1:0];

   assign req_take   = req_valid & req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign sym_ok     = 32'(req_payload.symbol_in) < 32'(LEAF_COUNT);
   assign req_leaf   = NW'(32'(req_payload.symbol_in) + 32'(LEAF_COUNT));
   assign child_sel  = cbit_ff ? cm_r : cm_l;
   assign child_leaf = child_ff >= FIRST_LEAF;
   assign emit_last  = DPW'(emit_ff + DPW'(1)) == depth_ff;
   assign depth_inc  = (depth_ff == DEPTH_MAX) ? depth_ff : DPW'(depth_ff + DPW'(1));
   assign ua_left    = cm_l == ua_ff;
   assign uncle      = ua_left ? cm_r : cm_l;
   assign swap_do    = wau_ff > nm_w;
   assign raise_sib  = (cm_l == ra_ff) ? cm_r : cm_l;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_NODE) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               if (cfg.mode == MODE_DECODE) st_in = ST_DEC_RD;
               else if (sym_ok)              st_in = ST_ENC_RD_PAR;
            end
         end
         ST_DEC_RD:  st_in = ST_DEC_SEL;
         ST_DEC_SEL: st_in = ST_DEC_EMIT;
         ST_DEC_EMIT: begin
            if (slot_free) st_in = child_leaf ? ST_UPD_RD_LEAF : ST_IDLE;
         end
         ST_ENC_RD_PAR:   st_in = ST_ENC_RD_CHILD;
         ST_ENC_RD_CHILD: st_in = ST_ENC_PUSH;
         ST_ENC_PUSH: begin
            st_in = (enc_par_ff == ROOT) ? ST_ENC_EMIT : ST_ENC_RD_PAR;
         end
         ST_ENC_EMIT: begin
            if (slot_free && emit_last) st_in = ST_UPD_RD_LEAF;
         end
         ST_UPD_RD_LEAF:  st_in = ST_UPD_INC;
         ST_UPD_INC:      st_in = ST_UPD_SIB;
         ST_UPD_SIB:      st_in = ST_RAISE_RD_SIB;
         ST_RAISE_RD_SIB: st_in = ST_RAISE_RD_PAR;
         ST_RAISE_RD_PAR: st_in = ST_RAISE_WR;
         ST_RAISE_WR: begin
            if (rpa_ff != ROOT)                    st_in = ST_RAISE_NEXT;
            else if (rwa_ff >= cfg.rescale_limit)  st_in = ST_HALVE_RD;
            else                                   st_in = ST_UPD_RESUME;
         end
         ST_RAISE_NEXT: st_in = ST_RAISE_RD_SIB;
         ST_HALVE_RD:   st_in = ST_HALVE_WR;
         ST_HALVE_WR: begin
            st_in = (idx_ff == LAST_NODE) ? ST_UPD_RESUME : ST_HALVE_RD;
         end
         ST_UPD_RESUME: begin
            if (ret_swap_ff) st_in = (uua_ff == ROOT) ? ST_IDLE : ST_SWAP_RD_UP;
            else             st_in = (leafpa_ff == ROOT) ? ST_IDLE : ST_SWAP_RD_UP;
         end
         ST_SWAP_RD_UP:    st_in = ST_SWAP_RD_UNCLE;
         ST_SWAP_RD_UNCLE: st_in = ST_SWAP_RD_W;
         ST_SWAP_RD_W:     st_in = ST_SWAP_CMP;
         ST_SWAP_CMP:      st_in = swap_do ? ST_SWAP_FIX : ST_UPD_RESUME;
         ST_SWAP_FIX:      st_in = ST_RAISE_RD_SIB;
         default:          st_in = ST_IDLE;
      endcase
   end

   // Memory ports, handshake and result loading.
   always_comb begin
      nm_we     = 1'b0;
      nm_waddr  = idx_ff;
      nm_wdata  = {nm_par, nm_w};
      nm_raddr  = idx_ff;
      cm_we     = 1'b0;
      cm_waddr  = idx_ff[CW-1:0];
      cm_wdata  = cm_rdata;
      cm_raddr  = cur_ff[CW-1:0];
      req_ready = 1'b0;
      out_load  = 1'b0;
      out_data  = '0;
      status.clearing = st_ff == ST_CLEAR;
      status.halving  = (st_ff == ST_HALVE_RD) || (st_ff == ST_HALVE_WR);
      unique case (st_ff)
         ST_CLEAR: begin
            nm_we    = 1'b1;
            nm_wdata = {1'b0, idx_ff[NW-1:1], WEIGHT_W'(1)};
            cm_we    = idx_ff < FIRST_LEAF;
            cm_wdata = {idx_ff[NW-2:0], 1'b0, idx_ff[NW-2:0], 1'b1};
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_DEC_RD: begin
            cm_raddr = cur_ff[CW-1:0];
         end
         ST_DEC_EMIT: begin
            out_load              = slot_free;
            out_data.symbol_valid = child_leaf;
            out_data.symbol_out   = child_leaf ? SYM_W'(child_ff - FIRST_LEAF) : '0;
            out_data.last         = 1'b1;
         end
         ST_ENC_RD_PAR: begin
            nm_raddr = enc_node_ff;
         end
         ST_ENC_RD_CHILD: begin
            cm_raddr = nm_par[CW-1:0];
         end
         ST_ENC_EMIT: begin
            out_load              = slot_free;
            out_data.code_bit_out = sr_ff[0];
            out_data.last         = emit_last;
         end
         ST_UPD_RD_LEAF: begin
            nm_raddr = leaf_ff;
         end
         ST_UPD_INC: begin
            nm_we    = 1'b1;
            nm_waddr = leaf_ff;
            nm_wdata = {nm_par, WEIGHT_W'(nm_w + WEIGHT_W'(1))};
            cm_raddr = nm_par[CW-1:0];
         end
         ST_RAISE_RD_SIB: begin
            nm_raddr = rb_ff;
         end
         ST_RAISE_RD_PAR: begin
            nm_raddr = rpa_ff;
         end
         ST_RAISE_WR: begin
            nm_we    = 1'b1;
            nm_waddr = rpa_ff;
            nm_wdata = {nm_par, rwa_ff};
            cm_raddr = nm_par[CW-1:0];
         end
         ST_HALVE_RD: begin
            nm_raddr = idx_ff;
         end
         ST_HALVE_WR: begin
            nm_we    = 1'b1;
            nm_waddr = idx_ff;
            nm_wdata = {nm_par, 1'b0, nm_w[WEIGHT_W-1:1]};
         end
         ST_SWAP_RD_UP: begin
            nm_raddr = ua_ff;
         end
         ST_SWAP_RD_UNCLE: begin
            cm_raddr = nm_par[CW-1:0];
            nm_raddr = au_ff;
         end
         ST_SWAP_RD_W: begin
            nm_raddr = uncle;
         end
         ST_SWAP_CMP: begin
            // The leaf-side node takes the uncle's place under the grandparent.
            nm_we    = swap_do;
            nm_waddr = bu_ff;
            nm_wdata = {ua_ff, nm_w};
            cm_we    = swap_do;
            cm_waddr = uua_ff[CW-1:0];
            cm_wdata = (ul_ff == ua_ff) ? {ul_ff, au_ff} : {au_ff, ur_ff};
            cm_raddr = ua_ff[CW-1:0];
         end
         ST_SWAP_FIX: begin
            nm_we    = 1'b1;
            nm_waddr = au_ff;
            nm_wdata = {uua_ff, wau_ff};
            cm_we    = 1'b1;
            cm_waddr = ua_ff[CW-1:0];
            cm_wdata = (cm_l == au_ff) ? {bu_ff, cm_r} : {cm_l, bu_ff};
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      cur_in      = cur_ff;
      leaf_in     = leaf_ff;
      child_in    = child_ff;
      enc_node_in = enc_node_ff;
      enc_par_in  = enc_par_ff;
      ra_in       = ra_ff;
      rpa_in      = rpa_ff;
      rb_in       = rb_ff;
      leafpa_in   = leafpa_ff;
      au_in       = au_ff;
      ua_in       = ua_ff;
      uua_in      = uua_ff;
      bu_in       = bu_ff;
      ul_in       = ul_ff;
      ur_in       = ur_ff;
      idx_in      = idx_ff;
      rwa_in      = rwa_ff;
      wau_in      = wau_ff;
      cbit_in     = cbit_ff;
      ret_swap_in = ret_swap_ff;
      sr_in       = sr_ff;
      depth_in    = depth_ff;
      emit_in     = emit_ff;
      rsp_in      = out_load ? out_data : rsp_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      unique case (st_ff)
         ST_CLEAR: begin
            idx_in = NW'(idx_ff + NW'(1));
         end
         ST_IDLE: begin
            if (req_take) begin
               cbit_in     = req_payload.code_bit_in;
               leaf_in     = req_leaf;
               enc_node_in = req_leaf;
               depth_in    = '0;
            end
         end
         ST_DEC_SEL: begin
            child_in = child_sel;
         end
         ST_DEC_EMIT: begin
            if (slot_free) begin
               cur_in  = child_leaf ? ROOT : child_ff;
               leaf_in = child_ff;
            end
         end
         ST_ENC_RD_CHILD: begin
            enc_par_in = nm_par;
         end
         ST_ENC_PUSH: begin
            // Bits are gathered leaf first, so the root bit ends at the bottom.
            sr_in       = {sr_ff[MAX_DEPTH-2:0], cm_r == enc_node_ff};
            depth_in    = depth_inc;
            enc_node_in = enc_par_ff;
            emit_in     = '0;
         end
         ST_ENC_EMIT: begin
            if (slot_free) begin
               sr_in   = {1'b0, sr_ff[MAX_DEPTH-1:1]};
               emit_in = DPW'(emit_ff + DPW'(1));
            end
         end
         ST_UPD_INC: begin
            ra_in       = leaf_ff;
            rpa_in      = nm_par;
            leafpa_in   = nm_par;
            rwa_in      = WEIGHT_W'(nm_w + WEIGHT_W'(1));
            ret_swap_in = 1'b0;
         end
         ST_UPD_SIB: begin
            rb_in = raise_sib;
         end
         ST_RAISE_RD_PAR: begin
            rwa_in = WEIGHT_W'(rwa_ff + nm_w);
         end
         ST_RAISE_WR: begin
            ra_in  = rpa_ff;
            rpa_in = nm_par;
            idx_in = ROOT;
         end
         ST_RAISE_NEXT: begin
            rb_in = raise_sib;
         end
         ST_HALVE_WR: begin
            idx_in = NW'(idx_ff + NW'(1));
         end
         ST_UPD_RESUME: begin
            if (ret_swap_ff) begin
               au_in = ua_ff;
               ua_in = uua_ff;
            end else begin
               au_in = leaf_ff;
               ua_in = leafpa_ff;
            end
         end
         ST_SWAP_RD_UNCLE: begin
            uua_in = nm_par;
         end
         ST_SWAP_RD_W: begin
            bu_in  = uncle;
            ul_in  = cm_l;
            ur_in  = cm_r;
            wau_in = nm_w;
         end
         ST_SWAP_CMP: begin
            rwa_in      = nm_w;
            ret_swap_in = 1'b1;
         end
         ST_SWAP_FIX: begin
            // Counts are redone from the uncle's new place upwards.
            ra_in  = bu_ff;
            rpa_in = ua_ff;
            rb_in  = (cm_l == au_ff) ? cm_r : cm_l;
         end
         default: begin
         end
      endcase
      if (cfg.cursor_home) cur_in = ROOT;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         idx_ff       <= '0;
         cur_ff       <= ROOT;
         rsp_valid_ff <= 1'b0;
         ret_swap_ff  <= 1'b0;
      end else begin
         st_ff        <= st_in;
         idx_ff       <= idx_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         ret_swap_ff  <= ret_swap_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      leaf_ff     <= leaf_in;
      child_ff    <= child_in;
      enc_node_ff <= enc_node_in;
      enc_par_ff  <= enc_par_in;
      ra_ff       <= ra_in;
      rpa_ff      <= rpa_in;
      rb_ff       <= rb_in;
      leafpa_ff   <= leafpa_in;
      au_ff       <= au_in;
      ua_ff       <= ua_in;
      uua_ff      <= uua_in;
      bu_ff       <= bu_in;
      ul_ff       <= ul_in;
      ur_ff       <= ur_in;
      rwa_ff      <= rwa_in;
      wau_ff      <= wau_in;
      cbit_ff     <= cbit_in;
      sr_ff       <= sr_in;
      depth_ff    <= depth_in;
      emit_ff     <= emit_in;
      rsp_ff      <= rsp_in;
   end

endmodule

/* src/adaptive_huffman_codec_core.sv */
// Channel  Direction  Handshake                  Payload
// req      in         req_valid / req_ready      req_payload (symbol_in, code_bit_in)
// rsp      out        rsp_valid / rsp_ready      rsp_payload (code_bit_out, symbol_out,
//                                                 symbol_valid, last)
// csr      in         csr_valid / csr_ready      csr_index, csr_data
//
// One item is worked on at a time. Encoding walks the leaf-to-root path level by level,
// then gives one bit a cycle while the result slot is free; decoding reads the child pair
// of the cursor and gives one result. The count update walks the path upwards, with a swap
// check plus a recount where due, and a halving sweep; all of it is set by the single
// read port of each table. After reset a clearing pass fills the tables; no item is
// taken meanwhile. A stalled result does not stop the count update behind it.
module adaptive_huffman_codec_core import ahc_pkg::*; #(
   parameter int LEAF_COUNT = 512,
   parameter int MAX_DEPTH  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NW  = $clog2(2 * LEAF_COUNT);
   localparam int CW  = NW - 1;
   localparam int NMW = NW + WEIGHT_W;
   localparam int CMW = 2 * NW;

   logic                mode_ff, mode_in;
   logic [WEIGHT_W-1:0] limit_ff, limit_in;
   logic                csr_take;
   cfg_type             cfg;
   status_type          status;

   logic           nm_we, cm_we;
   logic [NW-1:0]  nm_waddr, nm_raddr;
   logic [NMW-1:0] nm_wdata, nm_rdata;
   logic [CW-1:0]  cm_waddr, cm_raddr;
   logic [CMW-1:0] cm_wdata, cm_rdata;

   // Configuration registers; writing the mode sends the decode cursor home.
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid & csr_ready;

   always_comb begin
      mode_in  = mode_ff;
      limit_in = limit_ff;
      if (csr_take) begin
         unique case (csr_index)
            CSR_MODE:  mode_in  = csr_data[0];
            CSR_LIMIT: limit_in = csr_data;
            default:   mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         limit_ff <= LIMIT_RESET;
      end else begin
         mode_ff  <= mode_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.mode          = mode_ff;
   assign cfg.rescale_limit = limit_ff;
   assign cfg.cursor_home   = csr_take && (csr_index == CSR_MODE);

   // Per-node table: parent and count.
   ahc_ram #(.WIDTH(NMW), .DEPTH(2 * LEAF_COUNT)) u_node_ram (
      .clock (clock),
      .we    (nm_we),
      .waddr (nm_waddr),
      .wdata (nm_wdata),
      .raddr (nm_raddr),
      .rdata (nm_rdata)
   );

   // Per internal node table: left and right child.
   ahc_ram #(.WIDTH(CMW), .DEPTH(LEAF_COUNT)) u_child_ram (
      .clock (clock),
      .we    (cm_we),
      .waddr (cm_waddr),
      .wdata (cm_wdata),
      .raddr (cm_raddr),
      .rdata (cm_rdata)
   );

   ahc_engine #(.LEAF_COUNT(LEAF_COUNT), .MAX_DEPTH(MAX_DEPTH)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .status      (status),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .nm_we       (nm_we),
      .nm_waddr    (nm_waddr),
      .nm_wdata    (nm_wdata),
      .nm_raddr    (nm_raddr),
      .nm_rdata    (nm_rdata),
      .cm_we       (cm_we),
      .cm_waddr    (cm_waddr),
      .cm_wdata    (cm_wdata),
      .cm_raddr    (cm_raddr),
      .cm_rdata    (cm_rdata)
   );

   // Encoding never reports a symbol.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == MODE_ENCODE) |->
         !rsp_payload.symbol_valid && (rsp_payload.symbol_out == '0))
      else $error("encode result carries a symbol");

   // Every decode item ends in exactly one result with no code bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == MODE_DECODE) |->
         rsp_payload.last && !rsp_payload.code_bit_out)
      else $error("decode result not flagged last");

   // No item is taken while the tables are being swept.
   assert property (@(posedge clock) disable iff (reset)
      status.clearing || status.halving |-> !req_ready)
      else $error("item taken during a table sweep");

endmodule

/* tb/sv/tb_adaptive_huffman_codec_core.sv */
`timescale 1ns / 1ps

module tb_adaptive_huffman_codec_core;
   import ahc_pkg::*;

   localparam int LEAVES     = 512;
   localparam int NODES      = 2 * LEAVES;
   localparam int DEPTH_CAP  = 64;
   localparam int ROOT       = 1;
   localparam int CYCLE_CAP  = 4000000;

   // Tracks the adaptive tree and holds the code results still to come.
   class huffman_scoreboard;
      int          up_link [NODES];
      int          left_link [LEAVES];
      int          right_link [LEAVES];
      logic [15:0] count [NODES];
      int          cursor;
      logic        op_mode;
      logic [15:0] halve_at;
      rsp_type     owed_q[$];
      int          errors;

      function new();
         for (int i = 0; i < NODES; i++) begin
            up_link[i] = i / 2;
            count[i]   = 16'd1;
         end
         for (int i = 0; i < LEAVES; i++) begin
            left_link[i]  = 2 * i;
            right_link[i] = 2 * i + 1;
         end
         cursor   = ROOT;
         op_mode  = MODE_ENCODE;
         halve_at = LIMIT_RESET;
         errors   = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function int sibling(int n);
         int p;
         p = up_link[n];
         return (left_link[p] == n) ? right_link[p] : left_link[p];
      endfunction

      // Recount from a node and its sibling up to the root, then halve if due.
      function void recount(int a, int b);
         int p;
         for (int g = 0; g < NODES; g++) begin
            p = up_link[a];
            count[p] = count[a] + count[b];
            a = p;
            if (a == ROOT) break;
            b = sibling(a);
         end
         if (count[ROOT] >= halve_at)
            for (int i = 1; i < NODES; i++) count[i] = count[i] >> 1;
      endfunction

      // Raise the counts along the symbol's path and move heavy nodes upwards.
      function void adapt(int sym);
         int a, ua, uua, b, c;
         a = sym + LEAVES;
         count[a] = count[a] + 16'd1;
         recount(a, sibling(a));
         if (up_link[a] == ROOT) return;
         ua = up_link[a];
         for (int g = 0; g < NODES; g++) begin
            uua = up_link[ua];
            b = (left_link[uua] == ua) ? right_link[uua] : left_link[uua];
            if (count[a] > count[b]) begin
               if (left_link[uua] == ua) right_link[uua] = a;
               else left_link[uua] = a;
               if (left_link[ua] == a) begin
                  left_link[ua] = b;
                  c = right_link[ua];
               end else begin
                  right_link[ua] = b;
                  c = left_link[ua];
               end
               up_link[b] = ua;
               up_link[a] = uua;
               recount(b, c);
            end
            a = ua;
            ua = up_link[a];
            if (ua == ROOT) break;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_MODE) begin
            op_mode = data[0];
            cursor  = ROOT;
         end else begin
            halve_at = data;
         end
      endfunction

      // Work out the results that one accepted item causes.
      function void note_item(req_type item);
         bit      path [LEAVES];
         int      depth, a, p, n, sym;
         rsp_type r;
         if (op_mode == MODE_ENCODE) begin
            sym = int'(item.symbol_in);
            if (sym >= LEAVES) return;
            a = sym + LEAVES;
            depth = 0;
            while (a != ROOT && depth < LEAVES) begin
               p = up_link[a];
               path[depth++] = (right_link[p] == a);
               a = p;
            end
            n = (depth < DEPTH_CAP) ? depth : DEPTH_CAP;
            for (int k = 0; k < n; k++) begin
               r = '0;
               r.code_bit_out = path[depth - 1 - k];
               r.last = (k + 1 == n);
               owed_q.push_back(r);
            end
            adapt(sym);
         end else begin
            r = '0;
            r.last = 1'b1;
            a = item.code_bit_in ? right_link[cursor] : left_link[cursor];
            if (a >= LEAVES) begin
               r.symbol_out   = SYM_W'(a - LEAVES);
               r.symbol_valid = 1'b1;
               adapt(a - LEAVES);
               cursor = ROOT;
            end else begin
               cursor = a;
            end
            owed_q.push_back(r);
         end
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = owed_q.pop_front();
         if (got.code_bit_out !== want.code_bit_out)
            report($sformatf("code_bit_out %b, wanted %b", got.code_bit_out, want.code_bit_out));
         if (got.symbol_out !== want.symbol_out)
            report($sformatf("symbol_out %0d, wanted %0d", got.symbol_out, want.symbol_out));
         if (got.symbol_valid !== want.symbol_valid)
            report($sformatf("symbol_valid %b, wanted %b", got.symbol_valid,
                             want.symbol_valid));
         if (got.last !== want.last)
            report($sformatf("last %b, wanted %b", got.last, want.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   huffman_scoreboard codes = new();
   int  cycles = 0;
   int  items_sent = 0;
   bit  calm = 1'b0;

   adaptive_huffman_codec_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Cycle count and run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("adaptive_huffman_codec_core test failed");
         $finish;
      end
   end

   // Result side: check each accepted result and stall at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) codes.check_result(rsp_payload);
         rsp_ready <= calm || ($urandom_range(99) >= 11);
      end
   end

   // Offer one input item, at times with a random gap ahead of it, and wait for acceptance.
   task automatic send_item(req_type item);
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      codes.note_item(item);
      items_sent++;
      calm = (items_sent >= 180 && items_sent < 240);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      codes.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every owed result has come and the count update has finished.
   task automatic settle();
      req_valid <= 1'b0;
      while (codes.owed_q.size() != 0) @(posedge clock);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_symbol(int sym);
      req_type item;
      item.symbol_in   = SYM_W'(sym);
      item.code_bit_in = 1'($urandom_range(1));
      send_item(item);
   endtask

   task automatic send_bit(bit b);
      req_type item;
      item.symbol_in   = SYM_W'($urandom_range(511));
      item.code_bit_in = b;
      send_item(item);
   endtask

   // Mostly a handful of hot symbols so that swaps build a lopsided tree.
   function automatic int pick_symbol();
      if ($urandom_range(99) < 70) return int'($urandom_range(7));
      return int'($urandom_range(511));
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed encoding: field extremes, then one symbol repeated to force swaps, then random symbols.
      send_symbol(0);
      send_symbol(511);
      send_symbol(256);
      send_symbol(255);
      send_symbol(1);
      send_symbol(510);
      repeat (10) send_symbol(3);
      repeat (60) send_symbol(pick_symbol());
      settle();

      // A middling limit so halving occurs during a longer encode run.
      write_csr(CSR_LIMIT, 16'd600);
      repeat (60) send_symbol(pick_symbol());
      settle();

      // A limit of 2: halving after every symbol, in both modes.
      write_csr(CSR_LIMIT, 16'd2);
      repeat (8) send_symbol(pick_symbol());
      settle();
      write_csr(CSR_MODE, MODE_DECODE);
      repeat (24) send_bit(1'($urandom_range(1)));
      settle();

      // Highest limit while decoding; all-left and all-right walks first.
      write_csr(CSR_LIMIT, 16'd65535);
      write_csr(CSR_MODE, MODE_DECODE);
      repeat (12) send_bit(1'b0);
      repeat (12) send_bit(1'b1);
      repeat (70) send_bit(1'($urandom_range(1)));
      settle();

      // Back to encoding; the cursor is reset by the mode write.
      write_csr(CSR_MODE, MODE_ENCODE);
      write_csr(CSR_LIMIT, 16'd1000);
      repeat (40) send_symbol(pick_symbol());
      settle();

      if (codes.errors == 0 && codes.owed_q.size() == 0) begin
         $display("adaptive_huffman_codec_core test passed");
      end else begin
         $display("adaptive_huffman_codec_core test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ahc_pkg.sv
src/ahc_ram.sv
src/ahc_engine.sv
src/adaptive_huffman_codec_core.sv
tb/sv/tb_adaptive_huffman_codec_core.sv
